// File: rtl/core/sqd_pkg.sv
package sqd_pkg;

  localparam int JOB_W       = 8;
  localparam int CFG_W       = 4;
  localparam int CHOSEN_W    = 3;
  localparam int MASK_W      = 8;
  localparam int TOTAL_W     = 8;
  localparam int OUT_TDATA_W = 24;

  // packed from the top bit down; chosen_queue sits in the lowest bits
  typedef struct packed {
    logic [2:0]          pad;
    logic [TOTAL_W-1:0]  total_waiting;
    logic [MASK_W-1:0]   finished_mask;
    logic                dropped;
    logic                placed;
    logic [CHOSEN_W-1:0] chosen_queue;
  } sqd_result_t;

endpackage

// File: rtl/core/sqd_ram.sv
module sqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/shortest_queue_dispatcher_unit.sv
// Join-shortest-queue dispatcher over MAX_QUEUES bounded job FIFOs.
// Input stream: one transaction per time tick. in_tuser set means a job
// arrives with in_tdata as its service time. Output stream: one result per
// tick with the chosen queue, placed/dropped flags, the mask of queues that
// retired a head job and the total jobs held (saturated at 255).
// cfg_we/cfg_wdata set the number of active queues (0 acts as 1, values
// above MAX_QUEUES act as MAX_QUEUES); write it only while idle.
// One sequencer walks the queues one at a time around a single job RAM:
// an arrival scans the N active counts and then places the job; service
// skips an empty queue and takes a busy one through a RAM read, then an
// update. A tick is accepted in the idle state, runs scan and place only
// on an arrival, then service, and posts its result in the output state.
// The result sits in an output register; the next tick is accepted while it
// waits, but the one after stalls until the receiver takes it.
// Reset empties every queue and sets the active count to 8. The job RAM is
// not cleared: only live entries are ever read.
module shortest_queue_dispatcher_unit
  import sqd_pkg::*;
#(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [JOB_W-1:0]       in_tdata,   // service_time[7:0]
  input  logic                   in_tuser,   // arrival
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // chosen_queue[2:0], placed, dropped,
                                             // finished_mask[7:0], total_waiting[7:0]
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int QW    = $clog2(MAX_QUEUES > 1 ? MAX_QUEUES : 2);
  localparam int SW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int NLW   = $clog2(MAX_QUEUES + 1);
  localparam int TW    = $clog2(MAX_QUEUES * QUEUE_DEPTH + 1);
  localparam int AW    = QW + SW;
  localparam int MXW   = MAX_QUEUES + MASK_W;
  localparam int CXW   = QW + CHOSEN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PLACE, S_SRD, S_SUPD, S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  active_r;
  logic [CW-1:0]     count_r   [MAX_QUEUES];
  logic [CW-1:0]     count_nxt [MAX_QUEUES];
  logic [SW-1:0]     head_r    [MAX_QUEUES];
  logic [SW-1:0]     head_nxt  [MAX_QUEUES];
  logic [TW-1:0]     total_r, total_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [QW-1:0]     chosen_r, chosen_nxt;
  logic [CW-1:0]     best_r, best_nxt;
  logic [JOB_W-1:0]  svc_r, svc_nxt;
  logic              placed_r, placed_nxt;
  logic              dropped_r, dropped_nxt;
  logic [MAX_QUEUES-1:0] mask_r, mask_nxt;
  logic              out_valid_r, out_valid_nxt;
  sqd_result_t       out_r, out_nxt;

  logic [NLW-1:0]    n_lim;
  logic              last_q;
  logic [QW-1:0]     rd_q;
  logic [CW-1:0]     cnt_rd;
  logic [SW-1:0]     head_rd;
  logic [CW:0]       slot_sum;
  logic [SW-1:0]     slot;
  logic [SW:0]       head_inc;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [JOB_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [JOB_W-1:0]  ram_rdata;
  logic [MXW-1:0]    mask_ext;
  logic [CXW-1:0]    chosen_ext;

  sqd_ram #(
    .WIDTH (JOB_W),
    .DEPTH (1 << AW)
  ) u_jobs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (active_r == '0) begin
      n_lim = NLW'(1);
    end else if (int'(active_r) > MAX_QUEUES) begin
      n_lim = NLW'(MAX_QUEUES);
    end else begin
      n_lim = NLW'(active_r);
    end
  end

  assign last_q  = (32'(q_r) + 32'd1) == 32'(n_lim);
  assign rd_q    = (state_r == S_PLACE) ? chosen_r : q_r;
  assign cnt_rd  = count_r[rd_q];
  assign head_rd = head_r[rd_q];

  // count is below the depth when placing, so one subtract wraps the slot
  always_comb begin
    slot_sum = (CW+1)'(head_rd) + (CW+1)'(cnt_rd);
    if (slot_sum >= (CW+1)'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - (CW+1)'(QUEUE_DEPTH);
    end
    slot = slot_sum[SW-1:0];
    head_inc = (SW+1)'(head_rd) + (SW+1)'(1);
    if (head_inc == (SW+1)'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end
  end

  assign ram_raddr  = {q_r, head_rd};
  assign mask_ext   = MXW'(mask_r);
  assign chosen_ext = CXW'(chosen_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    total_nxt     = total_r;
    q_nxt         = q_r;
    chosen_nxt    = chosen_r;
    best_nxt      = best_r;
    svc_nxt       = svc_r;
    placed_nxt    = placed_r;
    dropped_nxt   = dropped_r;
    mask_nxt      = mask_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    ram_waddr     = {q_r, head_rd};
    ram_wdata     = ram_rdata - JOB_W'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          svc_nxt     = in_tdata;
          q_nxt       = '0;
          chosen_nxt  = '0;
          best_nxt    = count_r[0];
          placed_nxt  = 1'b0;
          dropped_nxt = 1'b0;
          mask_nxt    = '0;
          state_nxt   = in_tuser ? S_SCAN : S_SRD;
        end
      end
      S_SCAN: begin
        if (cnt_rd < best_r) begin
          best_nxt   = cnt_rd;
          chosen_nxt = q_r;
        end
        if (last_q) begin
          state_nxt = S_PLACE;
        end else begin
          q_nxt = q_r + QW'(1);
        end
      end
      S_PLACE: begin
        if (cnt_rd >= CW'(QUEUE_DEPTH)) begin
          dropped_nxt = 1'b1;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = {chosen_r, slot};
          ram_wdata       = svc_r;
          count_nxt[rd_q] = cnt_rd + CW'(1);
          total_nxt       = total_r + TW'(1);
          placed_nxt      = 1'b1;
        end
        q_nxt     = '0;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        // empty queue: skip without touching the RAM
        if (cnt_rd != '0) begin
          state_nxt = S_SUPD;
        end else if (last_q) begin
          state_nxt = S_OUT;
        end else begin
          q_nxt = q_r + QW'(1);
        end
      end
      S_SUPD: begin
        if (ram_rdata <= JOB_W'(1)) begin
          head_nxt[rd_q]  = head_inc[SW-1:0];
          count_nxt[rd_q] = cnt_rd - CW'(1);
          total_nxt       = total_r - TW'(1);
          mask_nxt[q_r]   = 1'b1;
        end else begin
          ram_we = 1'b1;
        end
        if (last_q) begin
          state_nxt = S_OUT;
        end else begin
          q_nxt     = q_r + QW'(1);
          state_nxt = S_SRD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_nxt.pad           = '0;
          out_nxt.chosen_queue  = chosen_ext[CHOSEN_W-1:0];
          out_nxt.placed        = placed_r;
          out_nxt.dropped       = dropped_r;
          out_nxt.finished_mask = mask_ext[MASK_W-1:0];
          if (32'(total_r) > 32'd255) begin
            out_nxt.total_waiting = '1;
          end else begin
            out_nxt.total_waiting = TOTAL_W'(total_r);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= CFG_W'(8);
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        count_r[i] <= '0;
        head_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
    end
    q_r       <= q_nxt;
    chosen_r  <= chosen_nxt;
    best_r    <= best_nxt;
    svc_r     <= svc_nxt;
    placed_r  <= placed_nxt;
    dropped_r <= dropped_nxt;
    mask_r    <= mask_nxt;
    out_r     <= out_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule
